// ===== src/dhcp_pkg.sv =====
// ----------------------------------------------------------------------------
// dhcp_pkg: shared constants, types and the option class table
// Definitions used by the DHCP frame option parser.
// ----------------------------------------------------------------------------
package dhcp_pkg;

  localparam int MaxTags  = 4;
  localparam int MaxFrame = 2048;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_CTAG = 16'h8100;
  localparam logic [15:0] ETH_STAG = 16'h88a8;
  localparam logic [7:0]  OPT_END  = 8'd255;
  localparam logic [7:0]  OPT_PAD  = 8'd0;

  typedef enum logic [1:0] {
    KIND_VLAN   = 2'd0,
    KIND_OPTION = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_ETH = 3'd1,
    ST_SHORT_TAG = 3'd2,
    ST_MANY_TAGS = 3'd3,
    ST_NOT_IPV4  = 3'd4,
    ST_SHORT_IP  = 3'd5,
    ST_TRUNC_OPT = 3'd6
  } status_t;

  // one result record; packs to 83 bits
  typedef struct packed {
    logic        last;
    logic [2:0]  status;
    logic [31:0] value_head;
    logic [10:0] option_offset;
    logic [4:0]  option_class;
    logic [7:0]  option_length;
    logic [7:0]  option_code;
    logic [11:0] vlan_id;
    logic        tag_type;
    logic [1:0]  record_kind;
  } rec_t;

  function automatic logic [4:0] class_of(input logic [7:0] code);
    logic [4:0] c;
    c = 5'd0;
    case (code)
      8'd0: c = 5'd1;
      8'd1, 8'd16, 8'd28, 8'd32, 8'd50, 8'd54, 8'd118: c = 5'd2;
      8'd12, 8'd14, 8'd15, 8'd17, 8'd18, 8'd40, 8'd56, 8'd62, 8'd64, 8'd66,
      8'd67, 8'd86, 8'd87, 8'd100, 8'd101, 8'd114, 8'd147: c = 5'd3;
      8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd41, 8'd42,
      8'd44, 8'd45, 8'd48, 8'd49, 8'd65, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72,
      8'd73, 8'd74, 8'd75, 8'd76, 8'd78, 8'd85, 8'd92, 8'd148, 8'd150,
      8'd162: c = 5'd4;
      8'd21: c = 5'd5;
      8'd33: c = 5'd6;
      8'd25: c = 5'd7;
      8'd13, 8'd22, 8'd26, 8'd57: c = 5'd8;
      8'd37, 8'd145: c = 5'd9;
      8'd23: c = 5'd10;
      8'd2, 8'd24, 8'd35, 8'd38, 8'd51, 8'd58, 8'd59, 8'd91, 8'd108, 8'd152,
      8'd153, 8'd154, 8'd155, 8'd211: c = 5'd11;
      8'd19, 8'd20, 8'd27, 8'd29, 8'd30, 8'd31, 8'd34, 8'd39: c = 5'd12;
      8'd36, 8'd46, 8'd52, 8'd53: c = 5'd13;
      8'd55: c = 5'd14;
      8'd81: c = 5'd15;
      8'd82: c = 5'd16;
      8'd63: c = 5'd17;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== src/dhcp_frame_option_parser_unit.sv =====
// ----------------------------------------------------------------------------
// dhcp_frame_option_parser_unit: DHCP option walker for Ethernet frames
// Strips VLAN tags, skips IPv4/UDP/BOOTP headers and reports DHCP options.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per transaction, in_tlast on the last byte.
//   out_* : result records. One byte yields zero, one or two records; a
//           record set always finishes with out_tlast on its last record.
//           Records: VLAN tag, DHCP option, frame end status (on in_tlast).
// Datapath: a byte is registered at the input, parsed by combinational logic
//   and its first record is loaded into the output register when the byte is
//   taken; a second record, if any, waits in a one-entry side buffer.
// Throughput: one byte per cycle while out_tready is high; a byte that yields
//   two records stalls the next byte while the second record drains.
// Reset: synchronous, rst_n low clears the parse state and drops both
//   output slots. While out_tready is low the output record holds and
//   in_tready falls once no storage is left for the next byte's records.
// ----------------------------------------------------------------------------
module dhcp_frame_option_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [11:0] vlan_id, [19:12] option_code,
                                  // [27:20] option_length, [32:28] option_class,
                                  // [43:33] option_offset, [75:44] value_head,
                                  // [78:76] status, [79] zero
  output logic [3:0]  out_tuser,  // [1:0] record_kind, [2] tag_type, [3] zero
  output logic        out_tlast   // last
);
  import dhcp_pkg::*;

  typedef enum logic [3:0] {
    PH_MAC, PH_TYPE, PH_TAG, PH_XTAG, PH_IPFIX, PH_IPOPT, PH_UDP, PH_BOOTP,
    PH_OPTCODE, PH_OPTLEN, PH_OPTVAL, PH_DONE
  } phase_t;

  // input register
  logic       iv_r;
  logic [7:0] ib_r;
  logic       il_r;

  // parse state
  logic [11:0] bc_r, bc_nxt;
  phase_t      ph_r, ph_nxt;
  logic [15:0] ts_r, ts_nxt;
  logic [2:0]  tc_r, tc_nxt;
  logic [10:0] hr_r, hr_nxt;
  logic [15:0] pr_r, pr_nxt;
  logic [7:0]  cc_r, cc_nxt;
  logic [7:0]  cl_r, cl_nxt;
  logic [10:0] co_r, co_nxt;
  logic [31:0] vg_r, vg_nxt;
  logic [2:0]  fs_r, fs_nxt;

  // output slot and side buffer
  logic ov_r, sv_r;
  rec_t orec_r, srec_r;

  rec_t r0, r1;
  logic [1:0] nrec;

  logic can_take;
  assign can_take = !sv_r && (!ov_r || out_tready);
  assign in_tready = !iv_r || can_take;

  function automatic rec_t opt_rec(input logic [7:0] c, input logic [7:0] l,
                                   input logic [10:0] o, input logic [31:0] v);
    rec_t r;
    r = '0;
    r.record_kind   = KIND_OPTION;
    r.option_code   = c;
    r.option_length = l;
    r.option_class  = class_of(c);
    r.option_offset = o;
    r.value_head    = v;
    return r;
  endfunction

  always_comb begin
    logic [15:0] t;
    logic [7:0]  b;
    logic [10:0] hrd;
    logic [15:0] prd;
    logic [7:0]  idx;
    logic        tail;
    logic [2:0]  st;
    rec_t        e [2];
    logic [1:0]  n;
    b = ib_r;
    bc_nxt = bc_r; ph_nxt = ph_r; ts_nxt = ts_r; tc_nxt = tc_r; hr_nxt = hr_r;
    pr_nxt = pr_r; cc_nxt = cc_r; cl_nxt = cl_r; co_nxt = co_r; vg_nxt = vg_r;
    fs_nxt = fs_r;
    e[0] = '0; e[1] = '0; n = 2'd0;
    hrd = hr_r - 11'd1;
    prd = pr_r - 16'd1;
    tail = 1'b0;
    t = {ts_r[7:0], b};
    idx = 8'd0;
    st = 3'd0;
    if (bc_r < 12'(MaxFrame)) begin
      bc_nxt = bc_r + 12'd1;
      case (ph_r)
        PH_MAC: if (bc_r >= 12'd11) begin
          ph_nxt = PH_TYPE; hr_nxt = 11'd2; ts_nxt = '0;
        end
        PH_TYPE: begin
          ts_nxt = t; hr_nxt = hrd;
          if (hrd == '0) begin
            ts_nxt = '0;
            if (t == ETH_IPV4) begin
              ph_nxt = PH_IPFIX; hr_nxt = 11'd20;
            end else if (t == ETH_CTAG || t == ETH_STAG) begin
              if (tc_r >= 3'(MaxTags)) begin
                ph_nxt = PH_XTAG; hr_nxt = 11'd4;
              end else begin
                cc_nxt = {7'd0, t == ETH_STAG}; ph_nxt = PH_TAG; hr_nxt = 11'd2;
              end
            end else begin
              fs_nxt = ST_NOT_IPV4; ph_nxt = PH_DONE;
            end
          end
        end
        PH_TAG: begin
          ts_nxt = t; hr_nxt = hrd;
          if (hrd == '0) begin
            e[0].record_kind = KIND_VLAN;
            e[0].tag_type = cc_r[0];
            e[0].vlan_id = t[11:0];
            n = 2'd1;
            tc_nxt = tc_r + 3'd1; cc_nxt = '0; ts_nxt = '0;
            ph_nxt = PH_TYPE; hr_nxt = 11'd2;
          end
        end
        PH_XTAG: begin
          hr_nxt = hrd;
          if (hrd == '0) begin
            fs_nxt = ST_MANY_TAGS; ph_nxt = PH_DONE;
          end
        end
        PH_IPFIX: begin
          hr_nxt = hrd;
          if (hr_r == 11'd20)
            cl_nxt = (b[3:0] < 4'd5) ? 8'd0 : {2'd0, b[3:0], 2'd0} - 8'd20;
          if (hrd == '0) begin
            if (cl_r != '0) begin
              ph_nxt = PH_IPOPT; hr_nxt = {3'd0, cl_r};
            end else begin
              ph_nxt = PH_UDP; hr_nxt = 11'd8;
            end
            cl_nxt = '0;
          end
        end
        PH_IPOPT: begin
          hr_nxt = hrd;
          if (hrd == '0) begin
            ph_nxt = PH_UDP; hr_nxt = 11'd8;
          end
        end
        PH_UDP: begin
          hr_nxt = hrd;
          if (hr_r == 11'd4 || hr_r == 11'd3) ts_nxt = t;
          if (hrd == '0) begin
            pr_nxt = (ts_r >= 16'd8) ? ts_r - 16'd8 : '0;
            ts_nxt = '0;
            if (ts_r <= 16'd8) ph_nxt = PH_DONE;
            else begin
              ph_nxt = PH_BOOTP; hr_nxt = 11'd240;
            end
          end
        end
        PH_BOOTP: begin
          pr_nxt = prd; hr_nxt = hrd;
          if (prd == '0) ph_nxt = PH_DONE;
          else if (hrd == '0) ph_nxt = PH_OPTCODE;
        end
        PH_OPTCODE: begin
          pr_nxt = prd;
          if (b == OPT_END) ph_nxt = PH_DONE;
          else begin
            tail = 1'b1;
            cc_nxt = b; cl_nxt = '0; vg_nxt = '0; co_nxt = bc_r[10:0];
            if (b == OPT_PAD) begin
              e[0] = opt_rec(b, 8'd0, bc_r[10:0], 32'd0); n = 2'd1;
            end else ph_nxt = PH_OPTLEN;
          end
        end
        PH_OPTLEN: begin
          pr_nxt = prd; tail = 1'b1;
          cl_nxt = b; hr_nxt = {3'd0, b};
          if (b == '0) begin
            e[0] = opt_rec(cc_r, 8'd0, co_r, vg_r); n = 2'd1;
            ph_nxt = PH_OPTCODE;
          end else ph_nxt = PH_OPTVAL;
        end
        PH_OPTVAL: begin
          pr_nxt = prd; tail = 1'b1; hr_nxt = hrd;
          idx = cl_r - hr_r[7:0];
          case (idx)
            8'd0: vg_nxt = vg_r | {b, 24'd0};
            8'd1: vg_nxt = vg_r | {8'd0, b, 16'd0};
            8'd2: vg_nxt = vg_r | {16'd0, b, 8'd0};
            8'd3: vg_nxt = vg_r | {24'd0, b};
            default: vg_nxt = vg_r;
          endcase
          if (hrd == '0) begin
            e[0] = opt_rec(cc_r, cl_r, co_r, vg_nxt); n = 2'd1;
            ph_nxt = PH_OPTCODE;
          end
        end
        default: ;
      endcase
      if (tail && pr_nxt == '0) begin
        if (ph_nxt == PH_OPTLEN || ph_nxt == PH_OPTVAL) begin
          e[n[0]] = opt_rec(cc_nxt, cl_nxt, co_nxt, vg_nxt);
          n = n + 2'd1;
          fs_nxt = ST_TRUNC_OPT;
        end
        ph_nxt = PH_DONE;
      end
    end
    if (il_r) begin
      st = fs_nxt;
      if (fs_nxt == ST_OK) begin
        case (ph_nxt)
          PH_MAC: st = ST_SHORT_ETH;
          PH_TYPE: st = (tc_nxt != '0) ? ST_SHORT_TAG : ST_SHORT_ETH;
          PH_TAG, PH_XTAG: st = ST_SHORT_TAG;
          PH_IPFIX: st = ST_SHORT_IP;
          PH_OPTLEN, PH_OPTVAL: begin
            e[n[0]] = opt_rec(cc_nxt, cl_nxt, co_nxt, vg_nxt);
            n = n + 2'd1;
            st = ST_TRUNC_OPT;
          end
          default: ;
        endcase
      end
      e[n[0]] = '0;
      e[n[0]].record_kind = KIND_STATUS;
      e[n[0]].status = st;
      n = n + 2'd1;
      bc_nxt = '0; ph_nxt = PH_MAC; ts_nxt = '0; tc_nxt = '0; hr_nxt = '0;
      pr_nxt = '0; cc_nxt = '0; cl_nxt = '0; co_nxt = '0; vg_nxt = '0;
      fs_nxt = '0;
    end
    if (n == 2'd1) e[0].last = 1'b1;
    if (n == 2'd2) e[1].last = 1'b1;
    r0 = e[0]; r1 = e[1]; nrec = n;
  end

  logic fire;
  assign fire = iv_r && can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0; ov_r <= 1'b0; sv_r <= 1'b0;
      bc_r <= '0; ph_r <= PH_MAC; ts_r <= '0; tc_r <= '0; hr_r <= '0;
      pr_r <= '0; cc_r <= '0; cl_r <= '0; co_r <= '0; vg_r <= '0; fs_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        iv_r <= 1'b1; ib_r <= in_tdata; il_r <= in_tlast;
      end else if (fire) iv_r <= 1'b0;
      if (fire) begin
        bc_r <= bc_nxt; ph_r <= ph_nxt; ts_r <= ts_nxt; tc_r <= tc_nxt;
        hr_r <= hr_nxt; pr_r <= pr_nxt; cc_r <= cc_nxt; cl_r <= cl_nxt;
        co_r <= co_nxt; vg_r <= vg_nxt; fs_r <= fs_nxt;
      end
      if (sv_r) begin
        if (out_tready) begin
          orec_r <= srec_r; sv_r <= 1'b0;
        end
      end else if (fire && nrec != 2'd0) begin
        ov_r <= 1'b1; orec_r <= r0;
        if (nrec == 2'd2) begin
          sv_r <= 1'b1; srec_r <= r1;
        end
      end else if (out_tready) ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, orec_r.status, orec_r.value_head, orec_r.option_offset,
                       orec_r.option_class, orec_r.option_length, orec_r.option_code,
                       orec_r.vlan_id};
  assign out_tuser  = {1'b0, orec_r.tag_type, orec_r.record_kind};
  assign out_tlast  = orec_r.last;

endmodule

// ===== dv/tb_dhcp_frame_option_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dhcp_frame_option_parser_unit: self-checking bench for the option parser
// Streams Ethernet frames byte by byte, predicts tag, option and status
// records in the bench and compares every output transaction field by field.
// ----------------------------------------------------------------------------
module tb_dhcp_frame_option_parser_unit;
  import dhcp_pkg::*;

  typedef enum logic [3:0] {
    P_MAC, P_TYPE, P_TAG, P_XTAG, P_IPFIX, P_IPOPT, P_UDP, P_BOOTP,
    P_OPTCODE, P_OPTLEN, P_OPTVAL, P_DONE
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        tag_type;
    logic [11:0] vlan_id;
    logic [7:0]  code;
    logic [7:0]  len;
    logic [4:0]  cls;
    logic [10:0] offset;
    logic [31:0] head;
    logic [2:0]  status;
    logic        last;
  } rec_s;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  dhcp_frame_option_parser_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  // parser model state
  int unsigned byte_cnt, tag_cnt, hdr_rem, pay_rem;
  phase_t      phase;
  logic [15:0] shreg;
  logic [7:0]  cur_code, cur_len;
  logic [10:0] cur_off;
  logic [31:0] gather;
  logic [2:0]  frm_status;

  rec_s expected_records[$];
  int   mismatches = 0;
  bit   no_idle = 1'b0;
  bit   hold_off = 1'b0;
  bit   stim_done = 1'b0;

  // one stimulus row: byte, end mark, typed expectation (if any)
  typedef struct {
    logic [7:0] b;
    logic       eop;
    bit         has_exp;
    logic [2:0] exp_status;
  } row_t;
  row_t frame_bytes[$];

  function automatic logic [4:0] opt_class(logic [7:0] c);
    case (c)
      0: return 1;
      1, 16, 28, 32, 50, 54, 118: return 2;
      12, 14, 15, 17, 18, 40, 56, 62, 64, 66, 67, 86, 87, 100, 101, 114, 147:
        return 3;
      3, 4, 5, 6, 7, 8, 9, 10, 11, 41, 42, 44, 45, 48, 49, 65, 68, 69, 70, 71,
      72, 73, 74, 75, 76, 78, 85, 92, 148, 150, 162: return 4;
      21: return 5;
      33: return 6;
      25: return 7;
      13, 22, 26, 57: return 8;
      37, 145: return 9;
      23: return 10;
      2, 24, 35, 38, 51, 58, 59, 91, 108, 152, 153, 154, 155, 211: return 11;
      19, 20, 27, 29, 30, 31, 34, 39: return 12;
      36, 46, 52, 53: return 13;
      55: return 14;
      81: return 15;
      82: return 16;
      63: return 17;
      default: return 0;
    endcase
  endfunction

  function automatic void clear_parser();
    byte_cnt = 0; phase = P_MAC; shreg = '0; tag_cnt = 0; hdr_rem = 0;
    pay_rem = 0; cur_code = '0; cur_len = '0; cur_off = '0; gather = '0;
    frm_status = ST_OK;
  endfunction

  function automatic void push_option(ref rec_s recs[$]);
    rec_s r;
    r = '0;
    r.kind = KIND_OPTION; r.code = cur_code; r.len = cur_len;
    r.cls = opt_class(cur_code); r.offset = cur_off; r.head = gather;
    recs.push_back(r);
  endfunction

  function automatic void parse_one(logic [7:0] b, ref rec_s recs[$]);
    int unsigned t, idx;
    rec_s r;
    case (phase)
      P_MAC: begin
        if (byte_cnt >= 11) begin
          phase = P_TYPE; hdr_rem = 2; shreg = '0;
        end
        return;
      end
      P_TYPE: begin
        shreg = {shreg[7:0], b};
        hdr_rem--;
        if (hdr_rem != 0) return;
        t = shreg; shreg = '0;
        if (t == ETH_IPV4) begin
          phase = P_IPFIX; hdr_rem = 20;
        end else if (t == ETH_CTAG || t == ETH_STAG) begin
          if (tag_cnt >= MaxTags) begin
            phase = P_XTAG; hdr_rem = 4;
          end else begin
            cur_code = (t == ETH_STAG); phase = P_TAG; hdr_rem = 2;
          end
        end else begin
          frm_status = ST_NOT_IPV4; phase = P_DONE;
        end
        return;
      end
      P_TAG: begin
        shreg = {shreg[7:0], b};
        hdr_rem--;
        if (hdr_rem == 0) begin
          r = '0; r.kind = KIND_VLAN; r.tag_type = cur_code[0];
          r.vlan_id = shreg[11:0];
          recs.push_back(r);
          tag_cnt++; cur_code = '0; shreg = '0; phase = P_TYPE; hdr_rem = 2;
        end
        return;
      end
      P_XTAG: begin
        hdr_rem--;
        if (hdr_rem == 0) begin
          frm_status = ST_MANY_TAGS; phase = P_DONE;
        end
        return;
      end
      P_IPFIX: begin
        if (hdr_rem == 20) begin
          t = b[3:0];
          if (t < 5) t = 5;
          cur_len = t * 4 - 20;
        end
        hdr_rem--;
        if (hdr_rem == 0) begin
          if (cur_len != 0) begin
            phase = P_IPOPT; hdr_rem = cur_len;
          end else begin
            phase = P_UDP; hdr_rem = 8;
          end
          cur_len = '0;
        end
        return;
      end
      P_IPOPT: begin
        hdr_rem--;
        if (hdr_rem == 0) begin
          phase = P_UDP; hdr_rem = 8;
        end
        return;
      end
      P_UDP: begin
        if (hdr_rem == 4 || hdr_rem == 3) shreg = {shreg[7:0], b};
        hdr_rem--;
        if (hdr_rem == 0) begin
          pay_rem = (shreg >= 8) ? shreg - 8 : 0;
          shreg = '0;
          if (pay_rem == 0) phase = P_DONE;
          else begin
            phase = P_BOOTP; hdr_rem = 240;
          end
        end
        return;
      end
      P_BOOTP: begin
        pay_rem--; hdr_rem--;
        if (pay_rem == 0) phase = P_DONE;
        else if (hdr_rem == 0) phase = P_OPTCODE;
        return;
      end
      P_OPTCODE: begin
        pay_rem--;
        if (b == OPT_END) begin
          phase = P_DONE;
          return;
        end
        cur_code = b; cur_len = '0; gather = '0; cur_off = byte_cnt[10:0];
        if (b == OPT_PAD) push_option(recs);
        else phase = P_OPTLEN;
      end
      P_OPTLEN: begin
        pay_rem--;
        cur_len = b; hdr_rem = b;
        if (b == 0) begin
          push_option(recs); phase = P_OPTCODE;
        end else phase = P_OPTVAL;
      end
      P_OPTVAL: begin
        pay_rem--;
        idx = cur_len - hdr_rem;
        if (idx < 4) gather |= 32'(b) << (8 * (3 - idx));
        hdr_rem--;
        if (hdr_rem == 0) begin
          push_option(recs); phase = P_OPTCODE;
        end
      end
      default: return;
    endcase
    if (pay_rem == 0) begin
      if (phase == P_OPTLEN || phase == P_OPTVAL) begin
        push_option(recs); frm_status = ST_TRUNC_OPT;
      end
      phase = P_DONE;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eop);
    rec_s recs[$];
    rec_s r;
    logic [2:0] st;
    if (byte_cnt < MaxFrame) begin
      parse_one(b, recs);
      byte_cnt++;
    end
    if (eop) begin
      st = frm_status;
      if (st == ST_OK) begin
        case (phase)
          P_MAC: st = ST_SHORT_ETH;
          P_TYPE: st = (tag_cnt != 0) ? ST_SHORT_TAG : ST_SHORT_ETH;
          P_TAG, P_XTAG: st = ST_SHORT_TAG;
          P_IPFIX: st = ST_SHORT_IP;
          P_OPTLEN, P_OPTVAL: begin
            push_option(recs); st = ST_TRUNC_OPT;
          end
          default: ;
        endcase
      end
      r = '0; r.kind = KIND_STATUS; r.status = st;
      recs.push_back(r);
      clear_parser();
    end
    if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) expected_records.push_back(recs[i]);
  endfunction

  // ---------------- frame builders ----------------
  task automatic add_byte(logic [7:0] b, logic eop = 1'b0);
    row_t r;
    r.b = b; r.eop = eop; r.has_exp = 1'b0; r.exp_status = ST_OK;
    frame_bytes.push_back(r);
  endtask

  // end-marked byte whose status record is known at a glance
  task automatic add_end(logic [7:0] b, logic [2:0] st);
    row_t r;
    r.b = b; r.eop = 1'b1; r.has_exp = 1'b1; r.exp_status = st;
    frame_bytes.push_back(r);
  endtask

  task automatic add_macs();
    repeat (12) add_byte($urandom_range(0, 255));
  endtask

  // DHCP frame builder; area_len is the option area, chop trims the tail
  task automatic build_frame(int ntags, int ihl, int udp_adj, int area_len,
                             bit use_end, int chop);
    logic [7:0] bytes[$];
    int opt_len, udp_len, n, code, len;
    repeat (12) bytes.push_back($urandom_range(0, 255));
    for (int i = 0; i < ntags; i++) begin
      if ($urandom_range(0, 1)) begin
        bytes.push_back(8'h88); bytes.push_back(8'ha8);
      end else begin
        bytes.push_back(8'h81); bytes.push_back(8'h00);
      end
      bytes.push_back($urandom_range(0, 255)); bytes.push_back($urandom_range(0, 255));
    end
    bytes.push_back(8'h08); bytes.push_back(8'h00);
    bytes.push_back({4'h4, 4'(ihl)});
    repeat (19) bytes.push_back($urandom_range(0, 255));
    for (int i = 20; i < ((ihl < 5) ? 5 : ihl) * 4; i++) bytes.push_back($urandom_range(0, 255));
    opt_len = 0;
    udp_len = 8 + 240 + area_len + udp_adj;
    if (udp_len < 0) udp_len = 0;
    repeat (4) bytes.push_back($urandom_range(0, 255));
    bytes.push_back(udp_len[15:8]); bytes.push_back(udp_len[7:0]);
    repeat (2) bytes.push_back($urandom_range(0, 255));
    repeat (240) bytes.push_back($urandom_range(0, 255));
    while (opt_len < area_len) begin
      case ($urandom_range(0, 9))
        0: code = 0;
        1: code = 255;
        default: code = $urandom_range(1, 254);
      endcase
      if (code == 255 && !use_end) code = 53;
      bytes.push_back(code); opt_len++;
      if (code == 0 || code == 255) continue;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      bytes.push_back(len); opt_len++;
      repeat (len) begin
        bytes.push_back($urandom_range(0, 255)); opt_len++;
      end
    end
    if (use_end) bytes.push_back(8'd255);
    repeat ($urandom_range(0, 3)) bytes.push_back($urandom_range(0, 255));
    n = bytes.size() - chop;
    if (n < 1) n = 1;
    for (int i = 0; i < n; i++) add_byte(bytes[i], i == n - 1);
  endtask

  task automatic build_noise();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 20);
    for (int i = 0; i < n; i++) add_byte($urandom_range(0, 255), i == n - 1);
  endtask

  // ---------------- driver ----------------
  task automatic send_row(row_t r);
    in_tvalid <= 1'b1; in_tdata <= r.b; in_tlast <= r.eop;
    do @(posedge clk); while (!in_tready);
    predict_byte(r.b, r.eop);
    if (r.has_exp && expected_records[$].status != r.exp_status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table status mismatch: row expects %0d, predictor %0d",
                 r.exp_status, expected_records[$].status);
    end
  endtask

  task automatic send_all();
    row_t r;
    while (frame_bytes.size() > 0) begin
      r = frame_bytes.pop_front();
      if (!no_idle && $urandom_range(0, 99) < 22) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      send_row(r);
    end
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        rec_s got, exp;
        got.kind = out_tuser[1:0]; got.tag_type = out_tuser[2];
        got.vlan_id = out_tdata[11:0]; got.code = out_tdata[19:12];
        got.len = out_tdata[27:20]; got.cls = out_tdata[32:28];
        got.offset = out_tdata[43:33]; got.head = out_tdata[75:44];
        got.status = out_tdata[78:76]; got.last = out_tlast;
        if (expected_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected record %h", got);
        end else begin
          exp = expected_records.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("record mismatch: exp %p got %p", exp, got);
          end
        end
      end
      out_tready <= hold_off ? 1'b0 : (no_idle || $urandom_range(0, 99) >= 22);
    end
  end

  // one long back-pressure stretch so the input stalls
  initial begin
    wait (rst_n);
    repeat (400) @(posedge clk);
    hold_off = 1'b1;
    repeat (150) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int items;
    clear_parser();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: short frames with obvious status, then special cases
    add_end(8'h00, ST_SHORT_ETH);
    add_macs(); add_byte(8'h08); add_end(8'h00, ST_SHORT_IP);
    add_macs(); add_byte(8'hff); add_end(8'hff, ST_NOT_IPV4);
    add_macs(); add_byte(8'h81); add_byte(8'h00); add_byte(8'hff);
    add_end(8'hff, ST_SHORT_TAG);
    add_macs(); add_byte(8'h88); add_end(8'ha8, ST_SHORT_TAG);
    send_all();
    build_frame(4, 5, 0, 20, 1, 0);       // tag limit reached, clean
    build_frame(5, 5, 0, 20, 1, 0);       // too many tags
    build_frame(0, 15, 0, 30, 1, 0);      // max IHL
    build_frame(0, 2, 0, 30, 1, 0);       // IHL below minimum
    build_frame(0, 5, -300, 30, 1, 0);    // UDP length below 8
    build_frame(0, 5, -5, 30, 0, 0);      // area ends inside option
    build_frame(1, 5, 40, 40, 0, 3);      // frame ends inside option
    build_frame(0, 5, 0, 0, 1, 100);      // ends in BOOTP header
    build_frame(0, 5, 2000, 2000, 0, 0);  // runs past max frame
    send_all();

    // random frames; middle stretch without idling
    items = 0;
    while (items < 950) begin
      no_idle = (items > 200 && items < 700);
      case ($urandom_range(0, 9))
        0, 1: build_noise();
        2: build_frame($urandom_range(0, 6), $urandom_range(0, 15),
                       $urandom_range(0, 1) ? 0 : $urandom_range(0, 40) - 20,
                       $urandom_range(0, 60), $urandom_range(0, 1),
                       $urandom_range(0, 30));
        default: build_frame($urandom_range(0, 2), 5, 0, $urandom_range(4, 40),
                             $urandom_range(0, 1), 0);
      endcase
      items += frame_bytes.size();
      send_all();
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;
    stim_done = 1'b1;
    while (expected_records.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
